### design/drsp_pkg.sv
package drsp_pkg;

    // Number of buttons: start/stop first, then the four reason buttons
    localparam int unsigned NUM_BTN = 5;
    localparam int unsigned BTN_START_STOP = 0;

    // Raw button levels, active low
    localparam logic LOW  = 1'b0;
    localparam logic HIGH = 1'b1;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS    = 2'd1;
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
    localparam logic [CFG_DATA_W-1:0] BLINK_TICKS_RST    = 16'd500;

    // Mode codes as seen on the result port
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_CODE_WAIT = 2'd2;

    // Event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_STOPPED = 2'd2;
    localparam logic [1:0] EV_REASON  = 2'd3;

    // Machine mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_RUN  = 3'b010,
        MODE_WAIT = 3'b100
    } mode_t;

    // One result transaction
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] event_res;
        logic [1:0] reason;
        logic       red_led;
        logic       green_led;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_IDLE: code = MODE_CODE_IDLE;
            MODE_RUN:  code = MODE_CODE_RUN;
            MODE_WAIT: code = MODE_CODE_WAIT;
            default:   code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### design/debounced_run_stop_reason_panel_unit.sv
// Run/stop panel with per-button debounce, a reason selector and LED drive.
// Input channel (in_valid/in_stall): one transaction per millisecond tick,
// carrying the five raw active-low button levels.
// Output channel (out_valid/out_stall): exactly one result per tick: mode,
// event code, reason code and the red/green LED levels after that tick.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 sets the
// debounce interval, index 1 the blink interval. Write only while idle.
// An accepted tick passes the input register, then the result register,
// before out_valid rises. Throughput: one tick per cycle unless a stalled
// result blocks it; mode and debounce state feed back through a single register stage.
// A stalled result holds in the output register; the input register still
// takes one more tick behind it, after which in_stall follows out_stall.
// Reset: buttons released, counters zero, mode idle, red lit, green dark,
// intervals back to 50 and 500 ticks.
module debounced_run_stop_reason_panel_unit #(
    parameter int unsigned TIMER_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_stop_raw,
    input  logic                                maintenance_raw,
    input  logic                                quality_raw,
    input  logic                                material_raw,
    input  logic                                tool_change_raw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          mode,
    output logic [1:0]                          event_res,
    output logic [1:0]                          reason,
    output logic                                red_led,
    output logic                                green_led,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import drsp_pkg::*;

    logic                  s1_valid_reg;
    logic [NUM_BTN-1:0]    s1_raw_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    logic                  advance;
    logic                  step;
    logic [CFG_DATA_W-1:0] debounce_ticks_reg;
    logic [CFG_DATA_W-1:0] blink_ticks_reg;
    logic [NUM_BTN-1:0]    press;
    logic [NUM_BTN-1:0]    sample_en;
    result_t               result;

    // Handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            blink_ticks_reg    <= BLINK_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_DEBOUNCE_TICKS)
            begin
                debounce_ticks_reg <= cfg_data;
            end
            else if (cfg_index == CFG_BLINK_TICKS)
            begin
                blink_ticks_reg <= cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_raw_reg <= {tool_change_raw, material_raw, quality_raw,
                           maintenance_raw, start_stop_raw};
        end
    end

    // One debouncer per button
    for (genvar g = 0; g < NUM_BTN; g++)
    begin : g_btn
        drsp_debounce #(
            .TIMER_BITS (TIMER_BITS)
        ) u_debounce (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (step),
            .sample_en      (sample_en[g]),
            .raw            (s1_raw_reg[g]),
            .debounce_ticks (debounce_ticks_reg),
            .press          (press[g])
        );
    end

    drsp_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .press       (press),
        .blink_ticks (blink_ticks_reg),
        .sample_en   (sample_en),
        .result      (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign mode      = out_reg.mode;
    assign event_res = out_reg.event_res;
    assign reason    = out_reg.reason;
    assign red_led   = out_reg.red_led;
    assign green_led = out_reg.green_led;

`ifndef SYNTHESIS
    a_reason_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_REASON) |-> (mode == MODE_CODE_IDLE))
        else $error("reason event without return to idle");

    a_reason_only_with_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_REASON) |-> (reason == 2'd0))
        else $error("reason code set without reason event");

    a_idle_leds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode == MODE_CODE_IDLE) |-> (red_led && !green_led))
        else $error("idle LED pattern wrong");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_STARTED) |-> (mode == MODE_CODE_RUN && !red_led))
        else $error("start event without running mode");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s1_valid_reg))
        else $error("input stalled without a blocked result");
`endif

endmodule

### design/drsp_debounce.sv
module drsp_debounce #(
    parameter int unsigned TIMER_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                sample_en,
    input  logic                                raw,
    input  logic [drsp_pkg::CFG_DATA_W-1:0]     debounce_ticks,
    output logic                                press
);
    import drsp_pkg::*;

    localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    logic                  prev_reg;
    logic                  stable_reg;
    logic [TIMER_BITS-1:0] cnt_reg;
    logic [TIMER_BITS-1:0] cnt_inc;
    logic                  changed;
    logic                  settle;

    // Elapsed time, saturating
    assign cnt_inc = (cnt_reg == {TIMER_BITS{1'b1}}) ? cnt_reg : TIMER_BITS'(cnt_reg + 1'b1);
    assign changed = (raw != prev_reg);

    // Level held long enough and differs from the stable one
    assign settle = !changed && (CMP_W'(cnt_inc) > CMP_W'(debounce_ticks))
                    && (raw != stable_reg);
    assign press  = settle && (raw == LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= HIGH;
            stable_reg <= HIGH;
            cnt_reg    <= '0;
        end
        else if (step)
        begin
            if (sample_en)
            begin
                prev_reg <= raw;
                cnt_reg  <= changed ? '0 : cnt_inc;
                if (settle)
                begin
                    stable_reg <= raw;
                end
            end
            else
            begin
                // Not sampled: level frozen, time still passes
                cnt_reg <= cnt_inc;
            end
        end
    end

endmodule

### design/drsp_ctrl.sv
module drsp_ctrl #(
    parameter int unsigned TIMER_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [drsp_pkg::NUM_BTN-1:0]        press,
    input  logic [drsp_pkg::CFG_DATA_W-1:0]     blink_ticks,
    output logic [drsp_pkg::NUM_BTN-1:0]        sample_en,
    output drsp_pkg::result_t                   result
);
    import drsp_pkg::*;

    localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    mode_t                 mode_reg;
    mode_t                 mode_a;
    mode_t                 mode_next;
    logic [TIMER_BITS-1:0] toggle_reg;
    logic [TIMER_BITS-1:0] toggle_inc;
    logic [TIMER_BITS-1:0] toggle_next;
    logic                  phase_reg;
    logic                  phase_next;
    logic                  red_reg;
    logic                  red_next;
    logic                  green_reg;
    logic                  green_next;
    logic [1:0]            event_a;
    logic [1:0]            event_code;
    logic [1:0]            reason_code;
    logic                  blink_hit;

    // Start/stop handling
    always_comb
    begin
        mode_a  = mode_reg;
        event_a = EV_NONE;
        if (press[BTN_START_STOP])
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    mode_a  = MODE_RUN;
                    event_a = EV_STARTED;
                end
                MODE_RUN:
                begin
                    mode_a  = MODE_WAIT;
                    event_a = EV_STOPPED;
                end
                MODE_WAIT: mode_a = MODE_WAIT;
                default:   mode_a = mode_reg;
            endcase
        end
    end

    // Reason buttons are sampled while waiting, until the first one fires
    always_comb
    begin
        sample_en[BTN_START_STOP] = 1'b1;
        sample_en[1] = (mode_a == MODE_WAIT);
        for (int i = 2; i < NUM_BTN; i++)
        begin
            sample_en[i] = sample_en[i-1] && !press[i-1];
        end
    end

    always_comb
    begin
        mode_next   = mode_a;
        event_code  = event_a;
        reason_code = 2'd0;
        for (int i = 1; i < NUM_BTN; i++)
        begin
            if (sample_en[i] && press[i])
            begin
                mode_next   = MODE_IDLE;
                event_code  = EV_REASON;
                reason_code = 2'(i - 1);
            end
        end
    end

    // LED drive and blink pacing
    assign toggle_inc = (toggle_reg == {TIMER_BITS{1'b1}}) ? toggle_reg
                        : TIMER_BITS'(toggle_reg + 1'b1);
    assign blink_hit  = (CMP_W'(toggle_inc) >= CMP_W'(blink_ticks));

    always_comb
    begin
        toggle_next = toggle_inc;
        phase_next  = phase_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        unique case (mode_next)
            MODE_IDLE:
            begin
                red_next   = 1'b1;
                green_next = 1'b0;
            end
            MODE_RUN:
            begin
                red_next = 1'b0;
                if (blink_hit)
                begin
                    toggle_next = '0;
                    phase_next  = !phase_reg;
                    green_next  = !phase_reg;
                end
            end
            MODE_WAIT:
            begin
                if (blink_hit)
                begin
                    toggle_next = '0;
                    phase_next  = !phase_reg;
                    red_next    = !phase_reg;
                    green_next  = phase_reg;
                end
            end
            default:
            begin
                red_next   = red_reg;
                green_next = green_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            toggle_reg <= '0;
            phase_reg  <= 1'b0;
            red_reg    <= 1'b1;
            green_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            toggle_reg <= toggle_next;
            phase_reg  <= phase_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

    assign result.mode      = mode_code(mode_next);
    assign result.event_res = event_code;
    assign result.reason    = reason_code;
    assign result.red_led   = red_next;
    assign result.green_led = green_next;

endmodule

### test/debounced_run_stop_reason_panel_unit_tb.sv
`timescale 1ns / 100ps

module debounced_run_stop_reason_panel_unit_tb;

    import drsp_pkg::*;

    localparam int unsigned TIMER_BITS = 17;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Button levels, bit i is button i: start/stop, maintenance, quality,
    // material, tool change
    localparam logic [NUM_BTN-1:0] ALL_RELEASED = '1;
    localparam logic [NUM_BTN-1:0] SS_HELD      = 5'b11110;

    // Hand-picked tick sequence, run with zero debounce and zero blink interval
    localparam logic [NUM_BTN-1:0] DIRECTED_LEVELS [23] = '{
        5'b11111, 5'b11110, 5'b11110,            // start
        5'b11111, 5'b11111, 5'b11110, 5'b11110,  // stop, enter waiting
        5'b11110, 5'b11111, 5'b11111,
        5'b11110, 5'b11110,                      // start/stop while waiting
        5'b11001, 5'b11001,                      // maintenance beats quality
        5'b11011, 5'b11010, 5'b11010,            // quality held, start again
        5'b11011, 5'b11011, 5'b11010, 5'b11010,  // stop and reason in one tick
        5'b00000, 5'b11111
    };

    // Random phases: debounce, blink interval, idling
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;
    localparam int PHASE_COUNT = 5;
    localparam logic [15:0] PHASE_DEBOUNCE [PHASE_COUNT] = '{16'd0, 16'd1, 16'd3, 16'd2, 16'd0};
    localparam logic [15:0] PHASE_BLINK [PHASE_COUNT] = '{16'd1, 16'd3, 16'd2, 16'd4, 16'd65535};
    localparam idling_t PHASE_IDLING [PHASE_COUNT] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                         IDLE_BOTH, IDLE_SENDER};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  start_stop_raw;
    logic                  maintenance_raw;
    logic                  quality_raw;
    logic                  material_raw;
    logic                  tool_change_raw;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            mode;
    logic [1:0]            event_res;
    logic [1:0]            reason;
    logic                  red_led;
    logic                  green_led;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned cur_debounce;

    // Panel predictor and store of results still owed by the block
    class panel_scoreboard;
        logic [15:0]           debounce_ticks;
        logic [15:0]           blink_ticks;
        logic [NUM_BTN-1:0]    stable_lvl;
        logic [NUM_BTN-1:0]    last_raw;
        logic [TIMER_BITS-1:0] since_change [NUM_BTN];
        logic [1:0]            run_mode;
        logic [TIMER_BITS-1:0] since_toggle;
        logic                  blink_phase;
        logic                  red_q;
        logic                  green_q;
        result_t               panel_results_due [$];
        int unsigned           failures;

        function new();
            debounce_ticks = DEBOUNCE_TICKS_RST;
            blink_ticks    = BLINK_TICKS_RST;
            stable_lvl     = '1;
            last_raw       = '1;
            foreach (since_change[i])
                since_change[i] = '0;
            run_mode     = MODE_CODE_IDLE;
            since_toggle = '0;
            blink_phase  = 1'b0;
            red_q        = 1'b1;
            green_q      = 1'b0;
            failures     = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE_TICKS: debounce_ticks = val;
                CFG_BLINK_TICKS:    blink_ticks    = val;
                default: ;
            endcase
        endfunction

        function logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] cnt);
            return (cnt == TIMER_MAX) ? cnt : cnt + 1'b1;
        endfunction

        // One debouncer; true when the stable level falls to pressed
        function bit fresh_press(input int btn, input logic raw);
            bit pressed;
            pressed = 1'b0;
            if (raw != last_raw[btn])
                since_change[btn] = '0;
            if (since_change[btn] > debounce_ticks && raw != stable_lvl[btn]) begin
                stable_lvl[btn] = raw;
                pressed = (raw == LOW);
            end
            last_raw[btn] = raw;
            return pressed;
        endfunction

        function void note_tick(input logic [NUM_BTN-1:0] raw);
            result_t due;
            due = '0;
            foreach (since_change[i])
                since_change[i] = bump(since_change[i]);
            since_toggle = bump(since_toggle);

            if (fresh_press(BTN_START_STOP, raw[BTN_START_STOP])) begin
                if (run_mode == MODE_CODE_IDLE) begin
                    run_mode      = MODE_CODE_RUN;
                    due.event_res = EV_STARTED;
                end else if (run_mode == MODE_CODE_RUN) begin
                    run_mode      = MODE_CODE_WAIT;
                    due.event_res = EV_STOPPED;
                end
            end

            // reason buttons are only looked at while waiting
            for (int i = 1; i < NUM_BTN; i++) begin
                if (run_mode == MODE_CODE_WAIT && fresh_press(i, raw[i])) begin
                    run_mode      = MODE_CODE_IDLE;
                    due.event_res = EV_REASON;
                    due.reason    = 2'(i - 1);
                end
            end

            // LEDs; the blink counter is left alone in idle
            case (run_mode)
                MODE_CODE_IDLE: begin
                    red_q   = 1'b1;
                    green_q = 1'b0;
                end
                MODE_CODE_RUN: begin
                    red_q = 1'b0;
                    if (since_toggle >= blink_ticks) begin
                        since_toggle = '0;
                        blink_phase  = ~blink_phase;
                        green_q      = blink_phase;
                    end
                end
                MODE_CODE_WAIT: begin
                    if (since_toggle >= blink_ticks) begin
                        since_toggle = '0;
                        blink_phase  = ~blink_phase;
                        red_q        = blink_phase;
                        green_q      = ~blink_phase;
                    end
                end
                default: ;
            endcase

            due.mode      = run_mode;
            due.red_led   = red_q;
            due.green_led = green_q;
            panel_results_due.push_back(due);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (panel_results_due.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", got);
                failures++;
                return;
            end
            want = panel_results_due.pop_front();
            if (got.mode !== want.mode) begin
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
                failures++;
            end
            if (got.event_res !== want.event_res) begin
                $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                failures++;
            end
            if (got.reason !== want.reason) begin
                $error("reason: expected %0d, got %0d", want.reason, got.reason);
                failures++;
            end
            if (got.red_led !== want.red_led) begin
                $error("red_led: expected %0d, got %0d", want.red_led, got.red_led);
                failures++;
            end
            if (got.green_led !== want.green_led) begin
                $error("green_led: expected %0d, got %0d", want.green_led, got.green_led);
                failures++;
            end
        endfunction

        function int pending();
            return panel_results_due.size();
        endfunction
    endclass

    panel_scoreboard sb;

    debounced_run_stop_reason_panel_unit #(
        .TIMER_BITS(TIMER_BITS)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .start_stop_raw  (start_stop_raw),
        .maintenance_raw (maintenance_raw),
        .quality_raw     (quality_raw),
        .material_raw    (material_raw),
        .tool_change_raw (tool_change_raw),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mode            (mode),
        .event_res       (event_res),
        .reason          (reason),
        .red_led         (red_led),
        .green_led       (green_led),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result({mode, event_res, reason, red_led, green_led});
    end

    task automatic set_idling(input idling_t kind);
        case (kind)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 83; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 83; end
            default:       begin send_idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    // One tick transaction; returns at the edge that accepts it
    task automatic drive_tick(input logic [NUM_BTN-1:0] lv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {tool_change_raw, material_raw, quality_raw, maintenance_raw, start_stop_raw} <= lv;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_tick(lv);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic configure(input logic [15:0] deb, input logic [15:0] blk);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom), 1'b0);
        write_reg(CFG_DEBOUNCE_TICKS, deb, 1'b0);
        write_reg(CFG_BLINK_TICKS, blk, 1'b1);
        cur_debounce = deb;
    endtask

    // Press/release sequences held long enough to debounce, with bounce
    // glitches, short holds and plain noise mixed in; drains once midway
    task automatic run_panel_phase(input int n_items);
        int                 sent;
        int                 hold;
        int                 pick;
        bit                 drained;
        logic [NUM_BTN-1:0] lv;
        logic [NUM_BTN-1:0] noisy;
        sent    = 0;
        drained = 1'b0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            lv   = ALL_RELEASED;
            if (pick >= 3 && pick < 5) begin
                lv = SS_HELD;
            end else if (pick >= 5 && pick < 8) begin
                if ($urandom_range(0, 1))
                    lv[$urandom_range(1, NUM_BTN - 1)] = LOW;
                else
                    lv[NUM_BTN-1:1] = 4'($urandom_range(0, 14));
            end else if (pick >= 8) begin
                lv = NUM_BTN'($urandom);
            end
            if (pick == 9 || $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, cur_debounce + 1);
            else
                hold = cur_debounce + 2 + $urandom_range(0, 2);
            repeat (hold) begin
                noisy = lv;
                if ($urandom_range(0, 24) == 0)
                    noisy[$urandom_range(0, NUM_BTN - 1)] ^= 1'b1;
                drive_tick(noisy);
                sent++;
            end
            if (!drained && sent >= n_items / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    // Timeout
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        start_stop_raw  = HIGH;
        maintenance_raw = HIGH;
        quality_raw     = HIGH;
        material_raw    = HIGH;
        tool_change_raw = HIGH;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_DEBOUNCE_TICKS;
        cfg_data        = '0;
        cur_debounce    = DEBOUNCE_TICKS_RST;
        set_idling(IDLE_NONE);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset intervals untouched
        run_panel_phase(120);
        wait_drained();

        // directed ticks: blink toggles every tick outside idle
        set_idling(IDLE_BOTH);
        configure(16'd0, 16'd0);
        foreach (DIRECTED_LEVELS[i])
            drive_tick(DIRECTED_LEVELS[i]);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_idling(PHASE_IDLING[p]);
            configure(PHASE_DEBOUNCE[p], PHASE_BLINK[p]);
            run_panel_phase(105);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
